// ===== src/assert_macros.svh =====
// assertion macros used by the rtl decoder
// checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define RVD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion name failed");

`define RVD_ASSERT_RST(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion name failed");

`else

`define RVD_ASSERT(name, clk, rst_n, prop)

`define RVD_ASSERT_RST(name, clk, prop)

`endif

`endif

// ===== src/rvdec_pkg.sv =====
// types and encoding constants for the rv32im instruction decoder
// no dependencies
package rvdec_pkg;

    localparam int unsigned InstrW = 32;
    localparam int unsigned RegW   = 5;

    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    localparam logic [11:0] F12_ECALL  = 12'h000;
    localparam logic [11:0] F12_EBREAK = 12'h001;

    localparam logic [InstrW-1:0] UpperMask = 32'hFFFFF000;

    typedef enum logic [5:0] {
        MN_ADDI, MN_ANDI, MN_ORI, MN_XORI, MN_SLTI, MN_SLTIU,
        MN_SLLI, MN_SRLI, MN_SRAI,
        MN_ADD, MN_SUB, MN_AND, MN_OR, MN_XOR, MN_SLL, MN_SRL, MN_SRA, MN_SLT, MN_SLTU,
        MN_SB, MN_SH, MN_SW,
        MN_LB, MN_LBU, MN_LH, MN_LHU, MN_LW,
        MN_BEQ, MN_BNE, MN_BLT, MN_BLTU, MN_BGE, MN_BGEU,
        MN_JAL, MN_JALR, MN_LUI, MN_AUIPC,
        MN_ECALL, MN_EBREAK,
        MN_MUL, MN_MULH, MN_MULHU, MN_MULHSU, MN_DIV, MN_DIVU, MN_REM, MN_REMU,
        MN_UNKNOWN
    } t_mnemonic;

    typedef enum logic [3:0] {
        FC_I, FC_SHIFT, FC_R, FC_S, FC_B, FC_J, FC_U, FC_LOAD, FC_JALR, FC_ENV, FC_UNK
    } t_format;

    typedef struct packed {
        t_mnemonic                mnemonic;
        t_format                  format_class;
        logic [RegW-1:0]          dest_reg;
        logic [RegW-1:0]          src1_reg;
        logic [RegW-1:0]          src2_reg;
        logic signed [InstrW-1:0] immediate;
        logic [RegW-1:0]          shift_amount;
    } t_decoded;

endpackage

// ===== src/rvdec_if.sv =====
// valid/ready channels of the rv32im instruction decoder
// depends on rvdec_pkg
interface rvdec_instr_if;
    import rvdec_pkg::*;

    logic              valid;
    logic              ready;
    logic [InstrW-1:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink (input valid, input instr_word, output ready);
endinterface

interface rvdec_result_if;
    import rvdec_pkg::*;

    logic                     valid;
    logic                     ready;
    t_mnemonic                mnemonic;
    t_format                  format_class;
    logic [RegW-1:0]          dest_reg;
    logic [RegW-1:0]          src1_reg;
    logic [RegW-1:0]          src2_reg;
    logic signed [InstrW-1:0] immediate;
    logic [RegW-1:0]          shift_amount;

    modport source (
        output valid, output mnemonic, output format_class, output dest_reg,
        output src1_reg, output src2_reg, output immediate, output shift_amount,
        input ready
    );
    modport sink (
        input valid, input mnemonic, input format_class, input dest_reg,
        input src1_reg, input src2_reg, input immediate, input shift_amount,
        output ready
    );
endinterface

// ===== src/rv32im_instruction_decoder.sv =====
// rv32im instruction decoder: input register, decode logic, result register
// depends on rvdec_pkg, rvdec_if and assert_macros.svh
//
//   channel    dir   beat
//   i_instr    in    one 32-bit instruction word
//   o_result   out   mnemonic, format, rd/rs1/rs2, immediate, shift amount
//
// one beat per cycle sustained while the output is not stalled; each beat passes
// through the input register and then the result register around the decode
// input is ready while the input register is empty or the result register is empty
// or drains in the same cycle, so a stalled output holds at most two beats
// synchronous active-low reset clears both valid flags
`include "assert_macros.svh"

module rv32im_instruction_decoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rvdec_instr_if.sink    i_instr,
    rvdec_result_if.source o_result
);
    import rvdec_pkg::*;

    logic              r_in_valid;
    logic [InstrW-1:0] r_in_word;
    logic              r_out_valid;
    t_decoded          r_out;
    t_decoded          n_out;

    logic              out_free;
    logic              in_free;

    logic [6:0]        w_opc;
    logic [2:0]        w_f3;
    logic [6:0]        w_f7;
    logic [11:0]       w_f12;
    t_mnemonic         dec_mn;
    t_format           dec_fc;

    assign w_opc = r_in_word[6:0];
    assign w_f3  = r_in_word[14:12];
    assign w_f7  = r_in_word[31:25];
    assign w_f12 = r_in_word[31:20];

    // mnemonic and format from opcode, funct3, funct7 and funct12
    always_comb begin
        dec_mn = MN_UNKNOWN;
        dec_fc = FC_UNK;
        case (w_opc)
            OPC_IMM: begin
                case (w_f3)
                    3'd0: dec_mn = MN_ADDI;
                    3'd2: dec_mn = MN_SLTI;
                    3'd3: dec_mn = MN_SLTIU;
                    3'd4: dec_mn = MN_XORI;
                    3'd6: dec_mn = MN_ORI;
                    3'd7: dec_mn = MN_ANDI;
                    3'd1: if (w_f7 == F7_BASE) dec_mn = MN_SLLI;
                    3'd5: begin
                        if (w_f7 == F7_BASE) dec_mn = MN_SRLI;
                        else if (w_f7 == F7_ALT) dec_mn = MN_SRAI;
                    end
                    default: dec_mn = MN_UNKNOWN;
                endcase
                if (dec_mn == MN_SLLI || dec_mn == MN_SRLI || dec_mn == MN_SRAI) begin
                    dec_fc = FC_SHIFT;
                end else if (dec_mn != MN_UNKNOWN) begin
                    dec_fc = FC_I;
                end
            end
            OPC_REG: begin
                if (w_f7 == F7_BASE) begin
                    case (w_f3)
                        3'd0:    dec_mn = MN_ADD;
                        3'd1:    dec_mn = MN_SLL;
                        3'd2:    dec_mn = MN_SLT;
                        3'd3:    dec_mn = MN_SLTU;
                        3'd4:    dec_mn = MN_XOR;
                        3'd5:    dec_mn = MN_SRL;
                        3'd6:    dec_mn = MN_OR;
                        default: dec_mn = MN_AND;
                    endcase
                end else if (w_f7 == F7_MULDIV) begin
                    case (w_f3)
                        3'd0:    dec_mn = MN_MUL;
                        3'd1:    dec_mn = MN_MULH;
                        3'd2:    dec_mn = MN_MULHSU;
                        3'd3:    dec_mn = MN_MULHU;
                        3'd4:    dec_mn = MN_DIV;
                        3'd5:    dec_mn = MN_DIVU;
                        3'd6:    dec_mn = MN_REM;
                        default: dec_mn = MN_REMU;
                    endcase
                end else if (w_f7 == F7_ALT && w_f3 == 3'd0) begin
                    dec_mn = MN_SUB;
                end else if (w_f7 == F7_ALT && w_f3 == 3'd5) begin
                    dec_mn = MN_SRA;
                end
                if (dec_mn != MN_UNKNOWN) dec_fc = FC_R;
            end
            OPC_STORE: begin
                case (w_f3)
                    3'd0:    dec_mn = MN_SB;
                    3'd1:    dec_mn = MN_SH;
                    3'd2:    dec_mn = MN_SW;
                    default: dec_mn = MN_UNKNOWN;
                endcase
                if (dec_mn != MN_UNKNOWN) dec_fc = FC_S;
            end
            OPC_LOAD: begin
                case (w_f3)
                    3'd0:    dec_mn = MN_LB;
                    3'd1:    dec_mn = MN_LH;
                    3'd2:    dec_mn = MN_LW;
                    3'd4:    dec_mn = MN_LBU;
                    3'd5:    dec_mn = MN_LHU;
                    default: dec_mn = MN_UNKNOWN;
                endcase
                if (dec_mn != MN_UNKNOWN) dec_fc = FC_LOAD;
            end
            OPC_BRANCH: begin
                case (w_f3)
                    3'd0:    dec_mn = MN_BEQ;
                    3'd1:    dec_mn = MN_BNE;
                    3'd4:    dec_mn = MN_BLT;
                    3'd5:    dec_mn = MN_BGE;
                    3'd6:    dec_mn = MN_BLTU;
                    3'd7:    dec_mn = MN_BGEU;
                    default: dec_mn = MN_UNKNOWN;
                endcase
                if (dec_mn != MN_UNKNOWN) dec_fc = FC_B;
            end
            OPC_JAL: begin
                dec_mn = MN_JAL;
                dec_fc = FC_J;
            end
            OPC_JALR: begin
                if (w_f3 == 3'd0) begin
                    dec_mn = MN_JALR;
                    dec_fc = FC_JALR;
                end
            end
            OPC_LUI: begin
                dec_mn = MN_LUI;
                dec_fc = FC_U;
            end
            OPC_AUIPC: begin
                dec_mn = MN_AUIPC;
                dec_fc = FC_U;
            end
            OPC_SYSTEM: begin
                if (w_f3 == 3'd0 && w_f12 == F12_ECALL) begin
                    dec_mn = MN_ECALL;
                    dec_fc = FC_ENV;
                end else if (w_f3 == 3'd0 && w_f12 == F12_EBREAK) begin
                    dec_mn = MN_EBREAK;
                    dec_fc = FC_ENV;
                end
            end
            default: begin
                dec_mn = MN_UNKNOWN;
                dec_fc = FC_UNK;
            end
        endcase
    end

    // operand fields selected by format, unused fields zero
    always_comb begin
        logic [InstrW-1:0] imm_i;
        logic [InstrW-1:0] imm_s;
        logic [InstrW-1:0] imm_b;
        logic [InstrW-1:0] imm_j;
        logic [InstrW-1:0] imm_u;
        logic [RegW-1:0]   rd;
        logic [RegW-1:0]   rs1;
        logic [RegW-1:0]   rs2;

        imm_i = {{20{r_in_word[31]}}, r_in_word[31:20]};
        imm_s = {{20{r_in_word[31]}}, r_in_word[31:25], r_in_word[11:7]};
        imm_b = {{19{r_in_word[31]}}, r_in_word[31], r_in_word[7], r_in_word[30:25],
                 r_in_word[11:8], 1'b0};
        imm_j = {{11{r_in_word[31]}}, r_in_word[31], r_in_word[19:12], r_in_word[20],
                 r_in_word[30:21], 1'b0};
        imm_u = r_in_word & UpperMask;
        rd    = r_in_word[11:7];
        rs1   = r_in_word[19:15];
        rs2   = r_in_word[24:20];

        n_out              = '0;
        n_out.mnemonic     = dec_mn;
        n_out.format_class = dec_fc;
        case (dec_fc)
            FC_I, FC_LOAD, FC_JALR: begin
                n_out.dest_reg  = rd;
                n_out.src1_reg  = rs1;
                n_out.immediate = imm_i;
            end
            FC_SHIFT: begin
                n_out.dest_reg     = rd;
                n_out.src1_reg     = rs1;
                n_out.shift_amount = rs2;
            end
            FC_R: begin
                n_out.dest_reg = rd;
                n_out.src1_reg = rs1;
                n_out.src2_reg = rs2;
            end
            FC_S: begin
                n_out.src1_reg  = rs1;
                n_out.src2_reg  = rs2;
                n_out.immediate = imm_s;
            end
            FC_B: begin
                n_out.src1_reg  = rs1;
                n_out.src2_reg  = rs2;
                n_out.immediate = imm_b;
            end
            FC_J: begin
                n_out.dest_reg  = rd;
                n_out.immediate = imm_j;
            end
            FC_U: begin
                n_out.dest_reg  = rd;
                n_out.immediate = imm_u;
            end
            default: begin
                n_out.dest_reg = '0;
            end
        endcase
    end

    assign out_free      = !r_out_valid || o_result.ready;
    assign in_free       = !r_in_valid || out_free;
    assign i_instr.ready = in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) r_in_valid <= i_instr.valid;
            if (out_free) r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_instr.valid) r_in_word <= i_instr.instr_word;
        if (out_free && r_in_valid) r_out <= n_out;
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.mnemonic     = r_out.mnemonic;
    assign o_result.format_class = r_out.format_class;
    assign o_result.dest_reg     = r_out.dest_reg;
    assign o_result.src1_reg     = r_out.src1_reg;
    assign o_result.src2_reg     = r_out.src2_reg;
    assign o_result.immediate    = r_out.immediate;
    assign o_result.shift_amount = r_out.shift_amount;

    `RVD_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_result.valid)
    `RVD_ASSERT(a_stage_advance, i_clk, i_rst_n, r_in_valid && out_free |=> r_out_valid)
    `RVD_ASSERT(a_unknown_clean, i_clk, i_rst_n, r_out_valid && r_out.mnemonic == MN_UNKNOWN |-> r_out.format_class == FC_UNK && r_out.immediate == 0 && r_out.dest_reg == 0)
    `RVD_ASSERT(a_shamt_only_shift, i_clk, i_rst_n, r_out_valid && r_out.shift_amount != 0 |-> r_out.format_class == FC_SHIFT)

endmodule

// ===== dv/rv32im_instruction_decoder_test.sv =====
// self-checking testbench for the rv32im instruction decoder
// directed rows then random instruction words checked against a decode predictor
// depends on rvdec_pkg, rvdec_if and rv32im_instruction_decoder
`timescale 1ns / 1ps

module rv32im_instruction_decoder_test;
    import rvdec_pkg::*;

    localparam int unsigned RandomItems = 425;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned DrainCycles = 10;

    typedef struct {
        logic [31:0] word;
        bit          typed;
        t_decoded    want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic sink_ready = 1'b0;

    rvdec_instr_if  instr_ch ();
    rvdec_result_if result_ch ();

    assign result_ch.ready = sink_ready;

    rv32im_instruction_decoder u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_instr  (instr_ch),
        .o_result (result_ch)
    );

    always #5 i_clk = ~i_clk;

    t_decoded    pending_decodes[$];
    t_stim_row   directed_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned beat_count     = 0;
    int unsigned unknown_count  = 0;
    int unsigned env_count      = 0;
    bit          mnemonic_seen[48];
    int unsigned cycle_count    = 0;
    int unsigned stall_span     = 0;
    int unsigned stall_mode     = 0;

    function automatic t_decoded mk_decoded(input t_mnemonic mn, input t_format fc,
                                            input logic [4:0] rd, input logic [4:0] rs1,
                                            input logic [4:0] rs2, input logic [31:0] imm,
                                            input logic [4:0] sh);
        t_decoded d;
        d.mnemonic     = mn;
        d.format_class = fc;
        d.dest_reg     = rd;
        d.src1_reg     = rs1;
        d.src2_reg     = rs2;
        d.immediate    = imm;
        d.shift_amount = sh;
        return d;
    endfunction

    // full decode of one instruction word
    function automatic t_decoded decode_word(input logic [31:0] w);
        logic [6:0] opc;
        logic [6:0] f7;
        logic [2:0] f3;
        logic [4:0] rd;
        logic [4:0] rs1;
        logic [4:0] rs2;
        t_decoded   d;
        opc = w[6:0];
        f3  = w[14:12];
        f7  = w[31:25];
        rd  = w[11:7];
        rs1 = w[19:15];
        rs2 = w[24:20];
        d = mk_decoded(MN_UNKNOWN, FC_UNK, '0, '0, '0, '0, '0);
        case (opc)
            OPC_IMM: begin
                case (f3)
                    3'd0: d.mnemonic = MN_ADDI;
                    3'd2: d.mnemonic = MN_SLTI;
                    3'd3: d.mnemonic = MN_SLTIU;
                    3'd4: d.mnemonic = MN_XORI;
                    3'd6: d.mnemonic = MN_ORI;
                    3'd7: d.mnemonic = MN_ANDI;
                    3'd1: begin
                        if (f7 == F7_BASE) d.mnemonic = MN_SLLI;
                    end
                    default: begin
                        if (f7 == F7_BASE) d.mnemonic = MN_SRLI;
                        else if (f7 == F7_ALT) d.mnemonic = MN_SRAI;
                    end
                endcase
                if (f3 == 3'd1 || f3 == 3'd5) begin
                    if (d.mnemonic != MN_UNKNOWN) begin
                        d.format_class = FC_SHIFT;
                        d.dest_reg     = rd;
                        d.src1_reg     = rs1;
                        d.shift_amount = rs2;
                    end
                end else begin
                    d.format_class = FC_I;
                    d.dest_reg     = rd;
                    d.src1_reg     = rs1;
                    d.immediate    = {{20{w[31]}}, w[31:20]};
                end
            end
            OPC_REG: begin
                case (f7)
                    F7_BASE: begin
                        case (f3)
                            3'd0: d.mnemonic = MN_ADD;
                            3'd1: d.mnemonic = MN_SLL;
                            3'd2: d.mnemonic = MN_SLT;
                            3'd3: d.mnemonic = MN_SLTU;
                            3'd4: d.mnemonic = MN_XOR;
                            3'd5: d.mnemonic = MN_SRL;
                            3'd6: d.mnemonic = MN_OR;
                            default: d.mnemonic = MN_AND;
                        endcase
                    end
                    F7_MULDIV: begin
                        case (f3)
                            3'd0: d.mnemonic = MN_MUL;
                            3'd1: d.mnemonic = MN_MULH;
                            3'd2: d.mnemonic = MN_MULHSU;
                            3'd3: d.mnemonic = MN_MULHU;
                            3'd4: d.mnemonic = MN_DIV;
                            3'd5: d.mnemonic = MN_DIVU;
                            3'd6: d.mnemonic = MN_REM;
                            default: d.mnemonic = MN_REMU;
                        endcase
                    end
                    F7_ALT: begin
                        if (f3 == 3'd0) d.mnemonic = MN_SUB;
                        else if (f3 == 3'd5) d.mnemonic = MN_SRA;
                    end
                    default: ;
                endcase
                if (d.mnemonic != MN_UNKNOWN) begin
                    d.format_class = FC_R;
                    d.dest_reg     = rd;
                    d.src1_reg     = rs1;
                    d.src2_reg     = rs2;
                end
            end
            OPC_STORE: begin
                case (f3)
                    3'd0: d.mnemonic = MN_SB;
                    3'd1: d.mnemonic = MN_SH;
                    3'd2: d.mnemonic = MN_SW;
                    default: ;
                endcase
                if (d.mnemonic != MN_UNKNOWN) begin
                    d.format_class = FC_S;
                    d.src1_reg     = rs1;
                    d.src2_reg     = rs2;
                    d.immediate    = {{20{w[31]}}, w[31:25], w[11:7]};
                end
            end
            OPC_LOAD: begin
                case (f3)
                    3'd0: d.mnemonic = MN_LB;
                    3'd1: d.mnemonic = MN_LH;
                    3'd2: d.mnemonic = MN_LW;
                    3'd4: d.mnemonic = MN_LBU;
                    3'd5: d.mnemonic = MN_LHU;
                    default: ;
                endcase
                if (d.mnemonic != MN_UNKNOWN) begin
                    d.format_class = FC_LOAD;
                    d.dest_reg     = rd;
                    d.src1_reg     = rs1;
                    d.immediate    = {{20{w[31]}}, w[31:20]};
                end
            end
            OPC_BRANCH: begin
                case (f3)
                    3'd0: d.mnemonic = MN_BEQ;
                    3'd1: d.mnemonic = MN_BNE;
                    3'd4: d.mnemonic = MN_BLT;
                    3'd5: d.mnemonic = MN_BGE;
                    3'd6: d.mnemonic = MN_BLTU;
                    3'd7: d.mnemonic = MN_BGEU;
                    default: ;
                endcase
                if (d.mnemonic != MN_UNKNOWN) begin
                    d.format_class = FC_B;
                    d.src1_reg     = rs1;
                    d.src2_reg     = rs2;
                    d.immediate    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
            end
            OPC_JAL: begin
                d.mnemonic     = MN_JAL;
                d.format_class = FC_J;
                d.dest_reg     = rd;
                d.immediate    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR: begin
                if (f3 == 3'd0) begin
                    d.mnemonic     = MN_JALR;
                    d.format_class = FC_JALR;
                    d.dest_reg     = rd;
                    d.src1_reg     = rs1;
                    d.immediate    = {{20{w[31]}}, w[31:20]};
                end
            end
            OPC_LUI, OPC_AUIPC: begin
                d.mnemonic     = (opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
                d.format_class = FC_U;
                d.dest_reg     = rd;
                d.immediate    = w & UpperMask;
            end
            OPC_SYSTEM: begin
                if (f3 == 3'd0 && w[31:20] == F12_ECALL) begin
                    d.mnemonic     = MN_ECALL;
                    d.format_class = FC_ENV;
                end else if (f3 == 3'd0 && w[31:20] == F12_EBREAK) begin
                    d.mnemonic     = MN_EBREAK;
                    d.format_class = FC_ENV;
                end
            end
            default: ;
        endcase
        return d;
    endfunction

    // mostly well-formed words with random fields, some broken functs, some noise
    function automatic logic [31:0] gen_word();
        logic [31:0] w;
        int unsigned pick;
        int unsigned sel;
        w    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick >= 95) return w;
        case ($urandom_range(0, 9))
            0: w[6:0] = OPC_IMM;
            1: w[6:0] = OPC_REG;
            2: w[6:0] = OPC_STORE;
            3: w[6:0] = OPC_LOAD;
            4: w[6:0] = OPC_BRANCH;
            5: w[6:0] = OPC_JAL;
            6: w[6:0] = OPC_JALR;
            7: w[6:0] = OPC_LUI;
            8: w[6:0] = OPC_AUIPC;
            default: w[6:0] = OPC_SYSTEM;
        endcase
        if (pick >= 85) return w;
        case (w[6:0])
            OPC_IMM: begin
                if (w[14:12] == 3'd1) w[31:25] = F7_BASE;
                else if (w[14:12] == 3'd5) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
            end
            OPC_REG: begin
                case ($urandom_range(0, 2))
                    0: w[31:25] = F7_BASE;
                    1: w[31:25] = F7_MULDIV;
                    default: begin
                        w[31:25] = F7_ALT;
                        w[14:12] = $urandom_range(0, 1) ? 3'd5 : 3'd0;
                    end
                endcase
            end
            OPC_STORE: w[14:12] = 3'($urandom_range(0, 2));
            OPC_LOAD: begin
                sel = $urandom_range(0, 4);
                w[14:12] = 3'((sel > 2) ? sel + 1 : sel);
            end
            OPC_BRANCH: begin
                sel = $urandom_range(0, 5);
                w[14:12] = 3'((sel > 1) ? sel + 2 : sel);
            end
            OPC_JALR: w[14:12] = 3'd0;
            OPC_SYSTEM: begin
                w[14:12] = 3'd0;
                w[31:20] = $urandom_range(0, 1) ? F12_EBREAK : F12_ECALL;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [31:0] w, input t_decoded want);
        instr_ch.valid      <= 1'b1;
        instr_ch.instr_word <= w;
        @(posedge i_clk);
        while (!instr_ch.ready) @(posedge i_clk);
        pending_decodes.push_back(want);
    endtask

    task automatic idle_cycles(input int unsigned n);
        instr_ch.valid      <= 1'b0;
        instr_ch.instr_word <= $urandom();
        repeat (n) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        instr_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_decodes.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic take_result();
        t_decoded want;
        if (pending_decodes.size() == 0) begin
            $error("result beat with no instruction pending");
            mismatch_count++;
        end else begin
            want = pending_decodes.pop_front();
            check_field("mnemonic", want.mnemonic, result_ch.mnemonic);
            check_field("format_class", want.format_class, result_ch.format_class);
            check_field("dest_reg", want.dest_reg, result_ch.dest_reg);
            check_field("src1_reg", want.src1_reg, result_ch.src1_reg);
            check_field("src2_reg", want.src2_reg, result_ch.src2_reg);
            check_field("immediate", want.immediate, result_ch.immediate);
            check_field("shift_amount", want.shift_amount, result_ch.shift_amount);
            beat_count++;
            mnemonic_seen[want.mnemonic] = 1'b1;
            if (want.format_class == FC_UNK) unknown_count++;
            if (want.format_class == FC_ENV) env_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) take_result();
    end

    // receiver stall pattern, picks a new stall mode whenever stall_span runs out
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            0: sink_ready <= 1'b1;
            1: sink_ready <= ($urandom_range(0, 3) != 0);
            2: sink_ready <= ((cycle_count % 6) < 4);
            default: sink_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("rv32im_instruction_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        t_decoded    unknown_decode;
        t_decoded    env_call;
        logic [31:0] w;
        int unsigned burst_left;
        int unsigned seen;
        instr_ch.valid      <= 1'b0;
        instr_ch.instr_word <= '0;
        i_rst_n             <= 1'b0;

        unknown_decode = mk_decoded(MN_UNKNOWN, FC_UNK, '0, '0, '0, '0, '0);
        env_call       = mk_decoded(MN_ECALL, FC_ENV, '0, '0, '0, '0, '0);
        directed_rows.push_back('{32'h00000000, 1'b1, unknown_decode});
        directed_rows.push_back('{32'hFFFFFFFF, 1'b1, unknown_decode});
        directed_rows.push_back('{32'hFFFF8F93, 1'b1,
            mk_decoded(MN_ADDI, FC_I, 5'd31, 5'd31, '0, 32'hFFFFFFFF, '0)});
        directed_rows.push_back('{32'h00000073, 1'b1, env_call});
        directed_rows.push_back('{32'h00100073, 1'b1,
            mk_decoded(MN_EBREAK, FC_ENV, '0, '0, '0, '0, '0)});
        // register fields of an ecall are ignored
        directed_rows.push_back('{32'h000F8F73, 1'b1, env_call});
        directed_rows.push_back('{32'h00200073, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h00001073, 1'b1, unknown_decode});
        directed_rows.push_back('{32'hFFFFF0B7, 1'b1,
            mk_decoded(MN_LUI, FC_U, 5'd1, '0, '0, 32'hFFFFF000, '0)});
        directed_rows.push_back('{32'h02001013, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h20005013, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h40001033, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h04000033, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h00001067, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h00003023, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h00003003, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h00002063, 1'b1, unknown_decode});
        directed_rows.push_back('{32'h00001017, 1'b0, unknown_decode});
        directed_rows.push_back('{32'h41F15093, 1'b0, unknown_decode});
        directed_rows.push_back('{32'h40000033, 1'b0, unknown_decode});
        directed_rows.push_back('{32'h03FFFFB3, 1'b0, unknown_decode});
        directed_rows.push_back('{32'hFFF08067, 1'b0, unknown_decode});
        directed_rows.push_back('{32'h800000EF, 1'b0, unknown_decode});
        directed_rows.push_back('{32'h7FFFF0EF, 1'b0, unknown_decode});
        directed_rows.push_back('{32'hFE000FA3, 1'b0, unknown_decode});
        directed_rows.push_back('{32'h80002003, 1'b0, unknown_decode});
        directed_rows.push_back('{32'hFE007FE3, 1'b0, unknown_decode});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_word(directed_rows[k].word,
                      directed_rows[k].typed ? directed_rows[k].want
                                             : decode_word(directed_rows[k].word));
        end
        hold_until_drained();

        burst_left = $urandom_range(1, 40);
        for (int unsigned n = 0; n < RandomItems; n++) begin
            if (n == RandomItems / 2) begin
                hold_until_drained();
            end else if (burst_left == 0) begin
                idle_cycles($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            w = gen_word();
            send_word(w, decode_word(w));
            if (burst_left != 0) burst_left--;
        end

        hold_until_drained();
        repeat (DrainCycles) @(posedge i_clk);

        seen = 0;
        foreach (mnemonic_seen[m]) seen += mnemonic_seen[m];
        $display("run covered %0d decoded beats and %0d of 48 mnemonic codes", beat_count, seen);
        $display("  of those, %0d unknown encodings and %0d ecall/ebreak words",
                 unknown_count, env_count);
        if (mismatch_count == 0) begin
            $display("rv32im_instruction_decoder: match");
        end else begin
            $display("rv32im_instruction_decoder: mismatch");
        end
        $finish;
    end

endmodule
